// ----- hdl/pdfc_pkg.sv -----
// Package: shared types, constants and the CRC-32/MPEG-2 byte step for the deframer.
`timescale 1ns / 1ps

package pdfc_pkg;

	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W = 1;
	localparam int MAX_LEN_W = 17;
	localparam int MIN_LEN_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'b1;

	// 64 KiB plus the section header and CRC overhead
	localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RESET = 17'd65541;
	localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RESET = 8'd11;

	localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
	localparam logic [31:0] CRC_POLY = 32'h04c1_1db7;

	// result queue depth and pointer width
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_CRC      = 3'd2,
		ST_OVERSIZE = 3'd3,
		ST_DISC     = 3'd4
	} status_t;

	typedef struct packed {
		status_t status;
		logic    unterminated;
		logic    in_sync;
	} verdict_t;

	// one data byte through the MSB-first CRC register
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		r = crc ^ {b, 24'h0};
		for (int i = 0; i < 8; i++) begin
			r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

endpackage

// ----- hdl/pdfc_if.sv -----
// Interfaces: byte input channel and verdict output channel.
`timescale 1ns / 1ps

interface pdfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       chunk_start;
	logic       packet_end;
	logic       discontinuity;

	modport source (output valid, data_byte, chunk_start, packet_end, discontinuity,
		input ready);
	modport sink (input valid, data_byte, chunk_start, packet_end, discontinuity,
		output ready);
endinterface

interface pdfc_out_if #(parameter int LENGTH_BITS = 17);
	logic                   valid;
	logic                   ready;
	logic [2:0]             status;
	logic [LENGTH_BITS-1:0] field_length;
	logic                   unterminated;
	logic                   in_sync;

	modport source (output valid, status, field_length, unterminated, in_sync,
		input ready);
	modport sink (input valid, status, field_length, unterminated, in_sync,
		output ready);
endinterface

// ----- hdl/pdfc_core.sv -----
// Packet state, running CRC and verdict logic; up to two verdicts per byte.
`timescale 1ns / 1ps

module pdfc_core #(
	parameter int LENGTH_BITS = 17
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic [7:0]                        data_byte,
	input  logic                              chunk_start,
	input  logic                              packet_end,
	input  logic                              discontinuity,
	input  logic [pdfc_pkg::MAX_LEN_W-1:0]    max_length,
	input  logic [pdfc_pkg::MIN_LEN_W-1:0]    min_length,
	output logic                              push0,
	output logic                              push1,
	output pdfc_pkg::verdict_t                verdict0,
	output pdfc_pkg::verdict_t                verdict1,
	output logic [LENGTH_BITS-1:0]            len0,
	output logic [LENGTH_BITS-1:0]            len1
);

	localparam int CW = ((LENGTH_BITS > pdfc_pkg::MAX_LEN_W) ?
		LENGTH_BITS : pdfc_pkg::MAX_LEN_W) + 1;

	logic                   open_q;
	logic [LENGTH_BITS-1:0] count_q;
	logic [31:0]            crc_q;
	logic                   sync_q;

	logic                   o;
	logic [LENGTH_BITS-1:0] c;
	logic [31:0]            k;
	logic                   s;
	logic                   done;
	logic [CW-1:0]          limit;
	logic [CW-1:0]          next_cnt;
	pdfc_pkg::verdict_t     jv;

	function automatic pdfc_pkg::verdict_t judge(input logic [LENGTH_BITS-1:0] cnt,
		input logic [31:0] crc, input logic [pdfc_pkg::MIN_LEN_W-1:0] min_len,
		input logic unterm);
		pdfc_pkg::verdict_t v;
		v.unterminated = unterm;
		if (CW'(cnt) < CW'(min_len)) begin
			v.status = pdfc_pkg::ST_SHORT;
			v.in_sync = 1'b0;
		end else if (crc != 32'h0) begin
			v.status = pdfc_pkg::ST_CRC;
			v.in_sync = 1'b0;
		end else begin
			v.status = pdfc_pkg::ST_OK;
			v.in_sync = 1'b1;
		end
		return v;
	endfunction

	// cap the length limit at what the counter can hold
	always_comb begin
		if (CW'(max_length) > CW'({LENGTH_BITS{1'b1}})) begin
			limit = CW'({LENGTH_BITS{1'b1}});
		end else begin
			limit = CW'(max_length);
		end
	end

	always_comb begin
		o = open_q;
		c = count_q;
		k = crc_q;
		s = sync_q;
		done = 1'b0;
		push0 = 1'b0;
		push1 = 1'b0;
		verdict0 = '0;
		verdict1 = '0;
		len0 = '0;
		len1 = '0;
		jv = '0;
		next_cnt = CW'(count_q) + CW'(1);

		// drop the open packet on a discontinuity
		if (discontinuity && o) begin
			s = 1'b0;
			push0 = 1'b1;
			verdict0.status = pdfc_pkg::ST_DISC;
			verdict0.unterminated = 1'b0;
			verdict0.in_sync = 1'b0;
			len0 = c;
			o = 1'b0;
			c = '0;
			k = pdfc_pkg::CRC_INIT;
		end

		if (chunk_start) begin
			if (o) begin
				jv = judge(c, k, min_length, 1'b1);
				s = jv.in_sync;
				push0 = 1'b1;
				verdict0 = jv;
				len0 = c;
			end
			o = 1'b1;
			k = pdfc_pkg::crc_byte(pdfc_pkg::CRC_INIT, data_byte);
			c = LENGTH_BITS'(1);
		end else if (o) begin
			if (next_cnt > limit) begin
				s = 1'b0;
				push0 = 1'b1;
				verdict0.status = pdfc_pkg::ST_OVERSIZE;
				verdict0.unterminated = 1'b0;
				verdict0.in_sync = 1'b0;
				len0 = c;
				o = 1'b0;
				c = '0;
				k = pdfc_pkg::CRC_INIT;
				done = 1'b1;
			end else begin
				k = pdfc_pkg::crc_byte(k, data_byte);
				c = next_cnt[LENGTH_BITS-1:0];
			end
		end else begin
			done = 1'b1;
		end

		// close on an end mark; goes behind any earlier verdict of this byte
		if (!done && packet_end) begin
			jv = judge(c, k, min_length, 1'b0);
			s = jv.in_sync;
			if (push0) begin
				push1 = 1'b1;
				verdict1 = jv;
				len1 = c;
			end else begin
				push0 = 1'b1;
				verdict0 = jv;
				len0 = c;
			end
			o = 1'b0;
			c = '0;
			k = pdfc_pkg::CRC_INIT;
		end

		if (!fire) begin
			push0 = 1'b0;
			push1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			count_q <= '0;
			crc_q <= pdfc_pkg::CRC_INIT;
			sync_q <= 1'b0;
		end else if (fire) begin
			open_q <= o;
			count_q <= c;
			crc_q <= k;
			sync_q <= s;
		end
	end

endmodule

// ----- hdl/pdfc_result_fifo.sv -----
// Small result queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps

module pdfc_result_fifo #(
	parameter int WIDTH = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push0,
	input  logic             push1,
	input  logic [WIDTH-1:0] wdata0,
	input  logic [WIDTH-1:0] wdata1,
	output logic             space2,
	output logic             rvalid,
	input  logic             rready,
	output logic [WIDTH-1:0] rdata
);

	localparam int CNT_W = pdfc_pkg::RES_PTR_W + 1;

	logic [WIDTH-1:0]                 mem_q [pdfc_pkg::RES_DEPTH];
	logic [pdfc_pkg::RES_PTR_W-1:0]   wptr_q;
	logic [pdfc_pkg::RES_PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic                             pop;
	logic [pdfc_pkg::RES_PTR_W-1:0]   wptr1;
	logic [CNT_W-1:0]                 n_push;

	assign pop = rvalid && rready;
	assign rvalid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];
	assign space2 = (cnt_q <= CNT_W'(pdfc_pkg::RES_DEPTH - 2));
	assign wptr1 = wptr_q + pdfc_pkg::RES_PTR_W'(1);
	assign n_push = CNT_W'(push0) + CNT_W'(push1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wptr_q] <= wdata0;
		end
		if (push1) begin
			mem_q[wptr1] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wptr_q <= wptr_q + n_push[pdfc_pkg::RES_PTR_W-1:0];
			if (pop) begin
				rptr_q <= rptr_q + pdfc_pkg::RES_PTR_W'(1);
			end
			cnt_q <= cnt_q + n_push - CNT_W'(pop);
		end
	end

endmodule

// ----- hdl/pes_data_field_crc_deframer.sv -----
// Top level: configuration registers, packet checker core and verdict queue.
`timescale 1ns / 1ps

// Checks a packet data field delivered one byte per transfer, with chunk start,
// packet end and discontinuity marks, against its trailing CRC-32/MPEG-2 (MSB
// first, init all ones, good when the register ends at zero over field plus
// CRC). Each closed packet gives one verdict: ok, too short, CRC error,
// oversize or discontinuity drop, with its byte count, an unterminated flag
// (closed by a new start rather than an end mark) and the sync flag after the
// verdict. One byte may close two packets and so give two verdicts. Bytes are
// taken at one per cycle: the byte's CRC step, count and judgement are done in
// the cycle of the transfer and the verdicts go into a four-entry queue that
// drives the output. The input holds off only while that queue has fewer than
// two free entries, as when the output side stalls or bytes keep closing two
// packets; verdicts leave the queue in order. Write max_length and
// min_length only while the block is idle; max_length is capped at the largest
// count that LENGTH_BITS can hold.
module pes_data_field_crc_deframer #(
	parameter int LENGTH_BITS = 17
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pdfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdfc_pkg::CFG_DATA_W-1:0]     cfg_data,
	pdfc_in_if.sink                             items,
	pdfc_out_if.source                          verdicts
);

	localparam int VW = $bits(pdfc_pkg::verdict_t);
	localparam int FW = VW + LENGTH_BITS;

	logic [pdfc_pkg::MAX_LEN_W-1:0] max_length_q;
	logic [pdfc_pkg::MIN_LEN_W-1:0] min_length_q;
	logic                           fire;
	logic                           push0;
	logic                           push1;
	pdfc_pkg::verdict_t             verdict0;
	pdfc_pkg::verdict_t             verdict1;
	pdfc_pkg::verdict_t             head;
	logic [LENGTH_BITS-1:0]         len0;
	logic [LENGTH_BITS-1:0]         len1;
	logic [FW-1:0]                  rdata;
	logic                           space2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= pdfc_pkg::MAX_LENGTH_RESET;
			min_length_q <= pdfc_pkg::MIN_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdfc_pkg::REG_MAX_LENGTH: max_length_q <= cfg_data[pdfc_pkg::MAX_LEN_W-1:0];
				pdfc_pkg::REG_MIN_LENGTH: min_length_q <= cfg_data[pdfc_pkg::MIN_LEN_W-1:0];
			endcase
		end
	end

	// take a byte whenever two result slots are free
	assign items.ready = space2;
	assign fire = items.valid && space2;

	pdfc_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.data_byte     (items.data_byte),
		.chunk_start   (items.chunk_start),
		.packet_end    (items.packet_end),
		.discontinuity (items.discontinuity),
		.max_length    (max_length_q),
		.min_length    (min_length_q),
		.push0         (push0),
		.push1         (push1),
		.verdict0      (verdict0),
		.verdict1      (verdict1),
		.len0          (len0),
		.len1          (len1)
	);

	pdfc_result_fifo #(
		.WIDTH (FW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (push0),
		.push1  (push1),
		.wdata0 ({verdict0, len0}),
		.wdata1 ({verdict1, len1}),
		.space2 (space2),
		.rvalid (verdicts.valid),
		.rready (verdicts.ready),
		.rdata  (rdata)
	);

	// unpack the queue head onto the verdict channel
	assign head = pdfc_pkg::verdict_t'(rdata[FW-1:LENGTH_BITS]);
	assign verdicts.status = head.status;
	assign verdicts.unterminated = head.unterminated;
	assign verdicts.in_sync = head.in_sync;
	assign verdicts.field_length = rdata[LENGTH_BITS-1:0];

endmodule

// ----- hdl/pdfc_checker.sv -----
// Port-level checker for the deframer, bound to the top level.
`timescale 1ns / 1ps

module pdfc_checker #(
	parameter int LENGTH_BITS = 17
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   v_valid,
	input logic                   v_ready,
	input logic [2:0]             v_status,
	input logic [LENGTH_BITS-1:0] v_length,
	input logic                   v_unterm,
	input logic                   v_sync
);

	// a stalled verdict holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_valid && !v_ready |=> v_valid && $stable({v_status, v_length, v_unterm, v_sync}))
		else $error("stalled verdict changed");

	// sync is set exactly on an ok verdict
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		v_valid |-> (v_sync == (v_status == pdfc_pkg::ST_OK)))
		else $error("sync flag does not match status");

	// an unterminated packet is always judged, never dropped
	a_unterm: assert property (@(posedge clk) disable iff (!arst_n)
		v_valid && v_unterm |-> (v_status == pdfc_pkg::ST_OK || v_status == pdfc_pkg::ST_SHORT ||
			v_status == pdfc_pkg::ST_CRC))
		else $error("unterminated flag on a drop verdict");

	// a closed packet always holds at least its first byte
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		v_valid |-> v_length != '0)
		else $error("verdict with zero length");

endmodule

bind pes_data_field_crc_deframer pdfc_checker #(
	.LENGTH_BITS (LENGTH_BITS)
) u_pdfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.v_valid  (verdicts.valid),
	.v_ready  (verdicts.ready),
	.v_status (verdicts.status),
	.v_length (verdicts.field_length),
	.v_unterm (verdicts.unterminated),
	.v_sync   (verdicts.in_sync)
);
